[rtl/core/i2c_mt_pkg.sv]
// Shared types and constants for the I2C master transaction engine.
package i2c_mt_pkg;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned COUNT_W = 16;

    localparam logic [LIMIT_W-1:0] RETRY_RESET = 10'd1000;
    localparam logic [7:0]         MSB_MASK    = 8'h80;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_PRESTOP = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST1     = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST2     = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST3     = 5'd4;
    localparam logic [PHASE_W-1:0] PH_TXD     = 5'd5;
    localparam logic [PHASE_W-1:0] PH_TXH     = 5'd6;
    localparam logic [PHASE_W-1:0] PH_TXL     = 5'd7;
    localparam logic [PHASE_W-1:0] PH_AKR     = 5'd8;
    localparam logic [PHASE_W-1:0] PH_AKH     = 5'd9;
    localparam logic [PHASE_W-1:0] PH_AKL     = 5'd10;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 5'd11;
    localparam logic [PHASE_W-1:0] PH_RXH     = 5'd12;
    localparam logic [PHASE_W-1:0] PH_RXL     = 5'd13;
    localparam logic [PHASE_W-1:0] PH_MAD     = 5'd14;
    localparam logic [PHASE_W-1:0] PH_MAH     = 5'd15;
    localparam logic [PHASE_W-1:0] PH_MAL     = 5'd16;
    localparam logic [PHASE_W-1:0] PH_STOP    = 5'd17;

    typedef struct packed {
        logic [1:0]         kind;
        logic               is_read;
        logic [7:0]         address_byte;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         write_data;
        logic               sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       need_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic       failed;
    } res_t;

endpackage

[rtl/core/i2c_mt_core.sv]
// Transaction state registers and the per-transaction bit-phase step logic.
module i2c_mt_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  i2c_mt_pkg::item_t             item,
    input  logic [i2c_mt_pkg::LIMIT_W-1:0] retry_limit,
    output i2c_mt_pkg::res_t              res
);
    import i2c_mt_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [2:0]         bit_index_reg, bit_index_next;
    logic [7:0]         shift_byte_reg, shift_byte_next;
    logic [COUNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [LIMIT_W-1:0] retries_done_reg, retries_done_next;
    logic               reading_reg, reading_next;
    logic [7:0]         saved_address_reg, saved_address_next;
    logic               scl_level_reg, scl_level_next;
    logic               sda_level_reg, sda_level_next;
    logic               addr_stage_reg, addr_stage_next;
    logic               nack_seen_reg, nack_seen_next;
    logic               end_failed_reg, end_failed_next;

    logic               sda_drive;
    logic               release_after;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W:0]   tries;
    logic [7:0]         rx_shift;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        shift_byte_next    = shift_byte_reg;
        bytes_left_next    = bytes_left_reg;
        retries_done_next  = retries_done_reg;
        reading_next       = reading_reg;
        saved_address_next = saved_address_reg;
        scl_level_next     = scl_level_reg;
        sda_drive          = sda_level_reg;
        addr_stage_next    = addr_stage_reg;
        nack_seen_next     = nack_seen_reg;
        end_failed_next    = end_failed_reg;
        release_after      = 1'b0;
        res                = '0;
        lim                = (retry_limit == '0) ? LIMIT_W'(1) : retry_limit;
        tries              = {1'b0, retries_done_reg} + (LIMIT_W+1)'(1);
        rx_shift           = {shift_byte_reg[6:0], item.sda_in};

        if (item.kind == KIND_START && phase_reg == PH_IDLE)
        begin
            reading_next       = item.is_read;
            saved_address_next = item.address_byte;
            bytes_left_next    = item.byte_count;
            retries_done_next  = '0;
            bit_index_next     = '0;
            addr_stage_next    = 1'b1;
            nack_seen_next     = 1'b0;
            end_failed_next    = 1'b0;
            phase_next         = item.is_read ? PH_ST1 : PH_PRESTOP;
        end
        else if (item.kind == KIND_BYTE && phase_reg == PH_WAIT)
        begin
            shift_byte_next = item.write_data;
            bit_index_next  = '0;
            phase_next      = PH_TXD;
        end
        else if (item.kind == KIND_TICK)
        begin
            unique case (phase_reg)
                PH_PRESTOP:
                begin
                    sda_drive      = 1'b0;
                    scl_level_next = 1'b1;
                    release_after  = 1'b1;
                    phase_next     = PH_ST1;
                end
                PH_ST1:
                begin
                    sda_drive       = 1'b1;
                    scl_level_next  = 1'b1;
                    shift_byte_next = saved_address_reg | {7'd0, reading_reg};
                    bit_index_next  = '0;
                    phase_next      = PH_ST2;
                end
                PH_ST2:
                begin
                    sda_drive  = 1'b0;
                    phase_next = PH_ST3;
                end
                PH_ST3:
                begin
                    scl_level_next = 1'b0;
                    phase_next     = PH_TXD;
                end
                PH_TXD:
                begin
                    sda_drive  = |(shift_byte_reg & MSB_MASK);
                    phase_next = PH_TXH;
                end
                PH_TXH:
                begin
                    scl_level_next = 1'b1;
                    phase_next     = PH_TXL;
                end
                PH_TXL:
                begin
                    scl_level_next = 1'b0;
                    if (bit_index_reg == 3'd7)
                    begin
                        sda_drive      = 1'b1;
                        bit_index_next = '0;
                        phase_next     = PH_AKR;
                    end
                    else
                    begin
                        bit_index_next  = bit_index_reg + 3'd1;
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                        phase_next      = PH_TXD;
                    end
                end
                PH_AKR:
                begin
                    sda_drive  = 1'b1;
                    phase_next = PH_AKH;
                end
                PH_AKH:
                begin
                    scl_level_next = 1'b1;
                    nack_seen_next = item.sda_in;
                    phase_next     = PH_AKL;
                end
                PH_AKL:
                begin
                    scl_level_next = 1'b0;
                    if (addr_stage_reg)
                    begin
                        if (nack_seen_reg)
                        begin
                            if (reading_reg || tries >= {1'b0, lim})
                            begin
                                end_failed_next = 1'b1;
                                phase_next      = PH_STOP;
                            end
                            else
                            begin
                                retries_done_next = tries[LIMIT_W-1:0];
                                phase_next        = PH_ST1;
                            end
                        end
                        else
                        begin
                            addr_stage_next = 1'b0;
                            if (bytes_left_reg == '0)
                            begin
                                end_failed_next = 1'b0;
                                phase_next      = PH_STOP;
                            end
                            else if (reading_reg)
                            begin
                                bit_index_next  = '0;
                                shift_byte_next = '0;
                                phase_next      = PH_RXH;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                    end
                    else if (nack_seen_reg)
                    begin
                        end_failed_next = 1'b1;
                        phase_next      = PH_STOP;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - COUNT_W'(1);
                        if (bytes_left_reg == COUNT_W'(1))
                        begin
                            end_failed_next = 1'b0;
                            phase_next      = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
                PH_RXH:
                begin
                    scl_level_next  = 1'b1;
                    shift_byte_next = rx_shift;
                    if (bit_index_reg == 3'd7)
                    begin
                        res.read_valid = 1'b1;
                        res.read_data  = rx_shift;
                    end
                    phase_next = PH_RXL;
                end
                PH_RXL:
                begin
                    scl_level_next = 1'b0;
                    if (bit_index_reg == 3'd7)
                    begin
                        bit_index_next = '0;
                        phase_next     = PH_MAD;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = PH_RXH;
                    end
                end
                PH_MAD:
                begin
                    sda_drive  = (bytes_left_reg == COUNT_W'(1));
                    phase_next = PH_MAH;
                end
                PH_MAH:
                begin
                    scl_level_next = 1'b1;
                    phase_next     = PH_MAL;
                end
                PH_MAL:
                begin
                    scl_level_next = 1'b0;
                    if (bytes_left_reg <= COUNT_W'(1))
                    begin
                        bytes_left_next = '0;
                        end_failed_next = 1'b0;
                        phase_next      = PH_STOP;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - COUNT_W'(1);
                        release_after   = 1'b1;
                        shift_byte_next = '0;
                        bit_index_next  = '0;
                        phase_next      = PH_RXH;
                    end
                end
                PH_STOP:
                begin
                    sda_drive       = 1'b0;
                    scl_level_next  = 1'b1;
                    release_after   = 1'b1;
                    res.done_res    = 1'b1;
                    res.failed      = end_failed_reg;
                    end_failed_next = 1'b0;
                    phase_next      = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end

        res.scl_out    = scl_level_next;
        res.sda_out    = sda_drive;
        res.busy_res   = (phase_next != PH_IDLE);
        res.need_byte  = (phase_next == PH_WAIT);
        sda_level_next = release_after ? 1'b1 : sda_drive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= '0;
            shift_byte_reg    <= '0;
            bytes_left_reg    <= '0;
            retries_done_reg  <= '0;
            reading_reg       <= 1'b0;
            saved_address_reg <= '0;
            scl_level_reg     <= 1'b1;
            sda_level_reg     <= 1'b1;
            addr_stage_reg    <= 1'b0;
            nack_seen_reg     <= 1'b0;
            end_failed_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            bytes_left_reg    <= bytes_left_next;
            retries_done_reg  <= retries_done_next;
            reading_reg       <= reading_next;
            saved_address_reg <= saved_address_next;
            scl_level_reg     <= scl_level_next;
            sda_level_reg     <= sda_level_next;
            addr_stage_reg    <= addr_stage_next;
            nack_seen_reg     <= nack_seen_next;
            end_failed_reg    <= end_failed_next;
        end
    end

endmodule

[rtl/core/i2c_master_transaction.sv]
// Top level of the I2C master transaction engine: handshakes, input and result registers.
// Each transaction on the input channel is one command: a tick that advances the bus by one
// bit phase, a start command, or a write byte. Every accepted transaction yields exactly one
// result transaction with the SCL/SDA levels for that phase and the status flags. The engine
// is a two-stage pipeline (input register, then step logic into a result register) and takes
// one transaction per clock when the result side does not stall; each command is held in
// the input register and its result in the result register; a stalled result stalls the
// input once the input register is also full. The address retry limit register resets to
// 1000 and must only be written while no command is in flight.
module i2c_master_transaction
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic                            is_read,
    input  logic [7:0]                      address_byte,
    input  logic [i2c_mt_pkg::COUNT_W-1:0]  byte_count,
    input  logic [7:0]                      write_data,
    input  logic                            sda_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            scl_out,
    output logic                            sda_out,
    output logic                            busy_res,
    output logic                            need_byte,
    output logic [7:0]                      read_data,
    output logic                            read_valid,
    output logic                            done_res,
    output logic                            failed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2c_mt_pkg::LIMIT_W-1:0]  cfg_data
);
    import i2c_mt_pkg::*;

    item_t              item_reg;
    logic               item_valid_reg;
    res_t               res_reg;
    logic               res_valid_reg;
    logic [LIMIT_W-1:0] limit_reg;
    res_t               step_res;
    logic               advance;

    assign advance   = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RETRY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.kind         <= kind;
            item_reg.is_read      <= is_read;
            item_reg.address_byte <= address_byte;
            item_reg.byte_count   <= byte_count;
            item_reg.write_data   <= write_data;
            item_reg.sda_in       <= sda_in;
        end
    end

    i2c_mt_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (item_reg),
        .retry_limit (limit_reg),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || !out_stall)
        begin
            res_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid  = res_valid_reg;
    assign scl_out    = res_reg.scl_out;
    assign sda_out    = res_reg.sda_out;
    assign busy_res   = res_reg.busy_res;
    assign need_byte  = res_reg.need_byte;
    assign read_data  = res_reg.read_data;
    assign read_valid = res_reg.read_valid;
    assign done_res   = res_reg.done_res;
    assign failed     = res_reg.failed;

endmodule

[rtl/core/i2c_mt_checker.sv]
// Port-level assertions for the I2C master transaction engine and their bind.
module i2c_mt_props
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       busy_res,
    input  logic       need_byte,
    input  logic [7:0] read_data,
    input  logic       read_valid,
    input  logic       done_res,
    input  logic       failed
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !need_byte)
        else $error("done reported while still busy");

    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failed |-> done_res)
        else $error("failed without done");

    a_read_data_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_data == 8'd0)
        else $error("read_data nonzero without read_valid");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_transaction i2c_mt_props u_i2c_mt_props
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .busy_res   (busy_res),
    .need_byte  (need_byte),
    .read_data  (read_data),
    .read_valid (read_valid),
    .done_res   (done_res),
    .failed     (failed)
);
